/* rtl/srb_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package srb_pkg;

    // Ring geometry
    localparam int BUFFER_DEPTH = 16;
    localparam int PTR_W        = $clog2(BUFFER_DEPTH);
    localparam int CNT_W        = $clog2(BUFFER_DEPTH + 1);

    // Field widths
    localparam int TIME_W      = 32;
    localparam int BYTE_W      = 8;
    localparam int RAW_W       = 20;
    localparam int HUM_W       = 14;
    localparam int TEMP_W      = 15;
    localparam int HUM_PROD_W  = RAW_W + HUM_W;
    localparam int TEMP_PROD_W = RAW_W + TEMP_W;

    // Scaling to hundredths: code * scale / 2^20, temperature offset by -50.00
    localparam logic [HUM_W-1:0]  HUM_SCALE   = HUM_W'(10000);
    localparam logic [TEMP_W-1:0] TEMP_SCALE  = TEMP_W'(20000);
    localparam logic [TEMP_W-1:0] TEMP_OFFSET = TEMP_W'(5000);

    // Command codes
    typedef enum logic {
        CMD_INSERT   = 1'b0,
        CMD_RETRIEVE = 1'b1
    } t_cmd;

    // One stored record
    typedef struct packed {
        logic [TIME_W-1:0] tstamp;
        logic [HUM_W-1:0]  hum;
        logic [TEMP_W-1:0] temp;
    } t_record;

    localparam int REC_W = $bits(t_record);

endpackage

`default_nettype wire

/* rtl/srb_ram.sv */
`timescale 1ns / 1ps
`default_nettype none

module srb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // One write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

/* rtl/sensor_frame_ring_buffer.sv */
// A retrieve passes the input register and then the result register before its result strobe shows.
// Throughput: one item per cycle; busy is never raised, results cannot be held off.
// The one-pass stage after the input register does conversion and pointer update,
// and the store's single write port and registered read port each take one access a cycle.
// Reset (i_rst_n low, synchronous) empties the ring: pointers, fill count and pipeline
// flags clear; store contents are left as they are, with no clearing pass.
`timescale 1ns / 1ps
`default_nettype none

module sensor_frame_ring_buffer
    import srb_pkg::*;
(
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    input  wire logic                     start,
    output logic                          busy,
    input  wire logic                     i_cmd,
    input  wire logic [TIME_W-1:0]        i_timestamp,
    input  wire logic [BYTE_W-1:0]        i_hum_byte_high,
    input  wire logic [BYTE_W-1:0]        i_hum_byte_mid,
    input  wire logic [BYTE_W-1:0]        i_split_byte,
    input  wire logic [BYTE_W-1:0]        i_temp_byte_mid,
    input  wire logic [BYTE_W-1:0]        i_temp_byte_low,
    output logic                          o_res_strobe,
    output logic                          o_valid_res,
    output logic        [TIME_W-1:0]      o_rec_time,
    output logic        [HUM_W-1:0]       o_humidity_centi,
    output logic signed [TEMP_W-1:0]      o_temperature_centi
);

    // Input register
    logic              r_in_valid;
    t_cmd              r_cmd;
    logic [TIME_W-1:0] r_timestamp;
    logic [RAW_W-1:0]  r_hum_raw;
    logic [RAW_W-1:0]  r_temp_raw;

    // Ring control
    logic [PTR_W-1:0] r_wr_ptr,  n_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr,  n_rd_ptr;
    logic [CNT_W-1:0] r_fill_cnt, n_fill_cnt;

    // Result control
    logic r_res_strobe, n_res_strobe;
    logic r_res_hit,    n_res_hit;

    logic                   accept;
    logic                   do_insert;
    logic                   do_retrieve;
    logic                   ring_empty;
    logic                   ring_full;
    logic [HUM_PROD_W-1:0]  hum_prod;
    logic [TEMP_PROD_W-1:0] temp_prod;
    logic [TEMP_W-1:0]      temp_scaled;
    t_record                wr_rec;
    t_record                rd_rec;
    logic                   ram_wr_en;
    logic                   ram_rd_en;

    assign busy   = 1'b0;
    assign accept = start & ~busy;

    // Capture item, unpacking the two 20-bit codes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_cmd       <= t_cmd'(i_cmd);
            r_timestamp <= i_timestamp;
            r_hum_raw   <= {i_hum_byte_high, i_hum_byte_mid, i_split_byte[7:4]};
            r_temp_raw  <= {i_split_byte[3:0], i_temp_byte_mid, i_temp_byte_low};
        end
    end

    // Conversion to hundredths
    always_comb begin
        hum_prod       = HUM_PROD_W'(r_hum_raw) * HUM_PROD_W'(HUM_SCALE);
        temp_prod      = TEMP_PROD_W'(r_temp_raw) * TEMP_PROD_W'(TEMP_SCALE);
        temp_scaled    = temp_prod[TEMP_PROD_W-1:RAW_W];
        wr_rec.tstamp  = r_timestamp;
        wr_rec.hum     = hum_prod[HUM_PROD_W-1:RAW_W];
        wr_rec.temp    = temp_scaled - TEMP_OFFSET;
    end

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(BUFFER_DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    // Pointer and fill count update
    always_comb begin
        ring_empty   = (r_fill_cnt == '0);
        ring_full    = (r_fill_cnt == CNT_W'(BUFFER_DEPTH));
        do_insert    = r_in_valid & (r_cmd == CMD_INSERT);
        do_retrieve  = r_in_valid & (r_cmd == CMD_RETRIEVE);
        ram_wr_en    = do_insert;
        ram_rd_en    = do_retrieve & ~ring_empty;
        n_wr_ptr     = r_wr_ptr;
        n_rd_ptr     = r_rd_ptr;
        n_fill_cnt   = r_fill_cnt;
        n_res_strobe = do_retrieve;
        n_res_hit    = ram_rd_en;
        if (do_insert) begin
            n_wr_ptr = ptr_inc(r_wr_ptr);
            if (ring_full) begin
                n_rd_ptr = ptr_inc(r_rd_ptr);
            end else begin
                n_fill_cnt = r_fill_cnt + CNT_W'(1);
            end
        end else if (ram_rd_en) begin
            n_rd_ptr   = ptr_inc(r_rd_ptr);
            n_fill_cnt = r_fill_cnt - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr     <= '0;
            r_rd_ptr     <= '0;
            r_fill_cnt   <= '0;
            r_res_strobe <= 1'b0;
            r_res_hit    <= 1'b0;
        end else begin
            r_wr_ptr     <= n_wr_ptr;
            r_rd_ptr     <= n_rd_ptr;
            r_fill_cnt   <= n_fill_cnt;
            r_res_strobe <= n_res_strobe;
            r_res_hit    <= n_res_hit;
        end
    end

    // Record store
    srb_ram #(
        .WIDTH (REC_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (ram_wr_en),
        .i_wr_addr (r_wr_ptr),
        .i_wr_data (wr_rec),
        .i_rd_en   (ram_rd_en),
        .i_rd_addr (r_rd_ptr),
        .o_rd_data (rd_rec)
    );

    // Result ports; an empty retrieve reads as zero
    always_comb begin
        o_res_strobe        = r_res_strobe;
        o_valid_res         = r_res_hit;
        o_rec_time          = r_res_hit ? rd_rec.tstamp : '0;
        o_humidity_centi    = r_res_hit ? rd_rec.hum    : '0;
        o_temperature_centi = r_res_hit ? rd_rec.temp   : '0;
    end

`ifndef SYNTHESIS
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill_cnt <= CNT_W'(BUFFER_DEPTH))
        else $error("fill count beyond ring depth");

    a_ptr_meet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_wr_ptr == r_rd_ptr) == (ring_empty || ring_full))
        else $error("pointers disagree with fill count");

    a_hit_strobed: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid_res |-> o_res_strobe)
        else $error("valid result without strobe");

    a_strobe_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res_strobe |-> $past(accept && (i_cmd == CMD_RETRIEVE), 2))
        else $error("result strobe without a retrieve two cycles back");

    a_insert_silent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        do_insert |=> !o_res_strobe)
        else $error("insert produced a result");
`endif

endmodule

`default_nettype wire
